// ----- hdl/vaf_pkg.sv -----
// ----------------------------------------------------------------------------
// vaf_pkg
// Shared types and constants for the VLAN-tagged ARP reply filter.
// ----------------------------------------------------------------------------
package vaf_pkg;

  // frame layout
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] FRAME_LEN    = 6'd46;
  localparam logic [POS_W-1:0] POS_DMAC     = 6'd0;
  localparam logic [POS_W-1:0] POS_TYPE     = 6'd12;
  localparam logic [POS_W-1:0] POS_TAG      = 6'd14;
  localparam logic [POS_W-1:0] POS_INNER    = 6'd16;
  localparam logic [POS_W-1:0] POS_OPCODE   = 6'd24;
  localparam logic [POS_W-1:0] POS_SMAC     = 6'd26;
  localparam logic [POS_W-1:0] POS_SPA      = 6'd32;
  localparam logic [POS_W-1:0] POS_TPA      = 6'd42;

  // protocol values
  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [15:0] OP_REPLY  = 16'd2;

  // config register indexes
  typedef enum logic [1:0] {
    CFG_LOCAL_MAC = 2'd0,
    CFG_LOCAL_IP  = 2'd1,
    CFG_VLAN_ID   = 2'd2,
    CFG_PEER_IP   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        frame_matched;
    logic        frame_short;
    logic [47:0] peer_mac;
  } out_item_t;

  typedef struct packed {
    logic [47:0] local_mac;
    logic [31:0] local_ip;
    logic [11:0] vlan_id;
    logic [31:0] peer_ip;
  } cfg_t;

endpackage

// ----- hdl/vaf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// vaf_cfg_regs
// Configuration registers: local MAC, local IP, VLAN id and peer IP.
// ----------------------------------------------------------------------------
module vaf_cfg_regs import vaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  cfg_idx_t    wr_index,
  input  logic [47:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_LOCAL_MAC: cfg_nxt.local_mac = wr_data;
        CFG_LOCAL_IP:  cfg_nxt.local_ip  = wr_data[31:0];
        CFG_VLAN_ID:   cfg_nxt.vlan_id   = wr_data[11:0];
        CFG_PEER_IP:   cfg_nxt.peer_ip   = wr_data[31:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/vaf_frame_check.sv -----
// ----------------------------------------------------------------------------
// vaf_frame_check
// Per-frame state: byte position, running field check and sender MAC
// capture. Produces the verdict for the byte currently presented.
// ----------------------------------------------------------------------------
module vaf_frame_check import vaf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      consume,
  output out_item_t result
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             ok_r;
  logic             ok_nxt;
  logic [47:0]      mac_r;
  logic [47:0]      mac_nxt;

  logic [POS_W-1:0] pos_step;
  logic             ok_step;
  logic [47:0]      mac_step;
  logic             chk;
  logic [7:0]       exp_byte;
  logic [7:0]       exp_mask;
  logic             in_range;
  logic             frame_short;

  assign in_range = (pos_r < FRAME_LEN);

  // expected value of the byte at the current offset
  always_comb begin
    chk      = 1'b0;
    exp_byte = 8'h00;
    exp_mask = 8'hFF;
    case (pos_r)
      POS_DMAC:              begin chk = 1'b1; exp_byte = cfg.local_mac[47:40]; end
      POS_DMAC + 6'd1:       begin chk = 1'b1; exp_byte = cfg.local_mac[39:32]; end
      POS_DMAC + 6'd2:       begin chk = 1'b1; exp_byte = cfg.local_mac[31:24]; end
      POS_DMAC + 6'd3:       begin chk = 1'b1; exp_byte = cfg.local_mac[23:16]; end
      POS_DMAC + 6'd4:       begin chk = 1'b1; exp_byte = cfg.local_mac[15:8];  end
      POS_DMAC + 6'd5:       begin chk = 1'b1; exp_byte = cfg.local_mac[7:0];   end
      POS_TYPE:              begin chk = 1'b1; exp_byte = TYPE_VLAN[15:8];      end
      POS_TYPE + 6'd1:       begin chk = 1'b1; exp_byte = TYPE_VLAN[7:0];       end
      POS_TAG: begin
        // priority and drop-eligible bits are ignored
        chk      = 1'b1;
        exp_byte = {4'h0, cfg.vlan_id[11:8]};
        exp_mask = 8'h0F;
      end
      POS_TAG + 6'd1:        begin chk = 1'b1; exp_byte = cfg.vlan_id[7:0];     end
      POS_INNER:             begin chk = 1'b1; exp_byte = TYPE_ARP[15:8];       end
      POS_INNER + 6'd1:      begin chk = 1'b1; exp_byte = TYPE_ARP[7:0];        end
      POS_OPCODE:            begin chk = 1'b1; exp_byte = OP_REPLY[15:8];       end
      POS_OPCODE + 6'd1:     begin chk = 1'b1; exp_byte = OP_REPLY[7:0];        end
      POS_SPA:               begin chk = 1'b1; exp_byte = cfg.peer_ip[31:24];   end
      POS_SPA + 6'd1:        begin chk = 1'b1; exp_byte = cfg.peer_ip[23:16];   end
      POS_SPA + 6'd2:        begin chk = 1'b1; exp_byte = cfg.peer_ip[15:8];    end
      POS_SPA + 6'd3:        begin chk = 1'b1; exp_byte = cfg.peer_ip[7:0];     end
      POS_TPA:               begin chk = 1'b1; exp_byte = cfg.local_ip[31:24];  end
      POS_TPA + 6'd1:        begin chk = 1'b1; exp_byte = cfg.local_ip[23:16];  end
      POS_TPA + 6'd2:        begin chk = 1'b1; exp_byte = cfg.local_ip[15:8];   end
      POS_TPA + 6'd3:        begin chk = 1'b1; exp_byte = cfg.local_ip[7:0];    end
      default: begin
        chk      = 1'b0;
        exp_byte = 8'h00;
        exp_mask = 8'hFF;
      end
    endcase
  end

  // sender MAC capture
  always_comb begin
    mac_step = mac_r;
    case (pos_r)
      POS_SMAC:          mac_step[47:40] = item.rx_byte;
      POS_SMAC + 6'd1:   mac_step[39:32] = item.rx_byte;
      POS_SMAC + 6'd2:   mac_step[31:24] = item.rx_byte;
      POS_SMAC + 6'd3:   mac_step[23:16] = item.rx_byte;
      POS_SMAC + 6'd4:   mac_step[15:8]  = item.rx_byte;
      POS_SMAC + 6'd5:   mac_step[7:0]   = item.rx_byte;
      default:           mac_step        = mac_r;
    endcase
  end

  // state after this byte, position saturates at the frame length
  assign pos_step = in_range ? pos_r + 6'd1 : pos_r;
  assign ok_step  = ok_r & (!chk || ((item.rx_byte & exp_mask) == exp_byte));

  // verdict, used only on the last byte
  assign frame_short          = (pos_step < FRAME_LEN);
  assign result.frame_matched = ok_step & !frame_short;
  assign result.frame_short   = frame_short;
  assign result.peer_mac      = mac_step;

  // advance or clear the frame state
  always_comb begin
    pos_nxt = pos_r;
    ok_nxt  = ok_r;
    mac_nxt = mac_r;
    if (consume) begin
      if (item.frame_end) begin
        pos_nxt = '0;
        ok_nxt  = 1'b1;
        mac_nxt = '0;
      end else begin
        pos_nxt = pos_step;
        ok_nxt  = ok_step;
        mac_nxt = mac_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ok_r  <= 1'b1;
      mac_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ok_r  <= ok_nxt;
      mac_r <= mac_nxt;
    end
  end

  // position never runs past the checked header
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= FRAME_LEN)
    else $error("byte position past frame length");

  // a consumed last byte leaves a fresh frame state
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    consume && item.frame_end |=> pos_r == '0 && ok_r && mac_r == '0)
    else $error("frame state not cleared after last byte");

endmodule

// ----- hdl/vlan_arp_reply_filter_core.sv -----
// ----------------------------------------------------------------------------
// vlan_arp_reply_filter_core
// Byte-serial filter that recognizes a VLAN-tagged ARP reply to our request.
// ----------------------------------------------------------------------------
// Frame bytes enter in wire order, one item per cycle while in_ready is high,
// with frame_end on the last byte. Each byte is registered, compared against
// the field expected at its offset (destination MAC, 0x8100 tag type, VLAN
// id, ARP type, reply opcode, sender and target IP) and folded into the
// per-frame state; the sender MAC at offsets 26..31 is captured. The last
// byte of a frame yields one result item: frame_matched, frame_short (fewer
// than 46 bytes) and the captured peer_mac. Sustained rate is one byte per
// cycle while pending results are taken, set by the single compare per byte.
// Configuration registers are to be written through cfg_* while no frame is
// in flight, which the block does not enforce, and take effect at once.
module vlan_arp_reply_filter_core import vaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [47:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  s_item_r;
  logic      s_valid_r;
  logic      s_valid_nxt;
  out_item_t result;
  out_item_t out_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      out_free;
  logic      s_fire;
  logic      in_fire;

  assign cfg_ready = 1'b1;

  vaf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake: middle bytes always drain, last bytes need a free result slot
  assign out_free = !out_valid_r || out_ready;
  assign s_fire   = s_valid_r && (!s_item_r.frame_end || out_free);
  assign in_ready = !s_valid_r || s_fire;
  assign in_fire  = in_valid && in_ready;

  vaf_frame_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (s_item_r),
    .consume (s_fire),
    .result  (result)
  );

  // input stage
  assign s_valid_nxt = in_fire ? 1'b1 : (s_fire ? 1'b0 : s_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_item_r <= in_data;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s_fire && s_item_r.frame_end) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_item_r.frame_end) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a short frame never matches
  a_short_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.frame_matched && out_data_r.frame_short))
    else $error("short frame reported as matched");

  // a held byte in the input stage is neither lost nor overwritten
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && !s_fire |=> s_valid_r && $stable(s_item_r))
    else $error("input stage overwritten while stalled");

  // a pending result is never overwritten by the next frame verdict
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(s_fire && s_item_r.frame_end))
    else $error("result overwritten before taken");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the VLAN-tagged ARP reply filter. Frames are fed a
// byte per item with random gaps and output stalls. A scoreboard class keeps
// its own copy of the registers and of the per-frame state, predicts each
// verdict from the accepted bytes and checks every result against it. The run
// steps through several register settings: reset values, all ones, all
// zeros and random values.
// ----------------------------------------------------------------------------
module tb_top;
  import vaf_pkg::*;

  localparam int PHASE_COUNT  = 6;
  localparam int PHASE_BYTES  = 275;
  localparam int PHASE_FRAMES = 10;
  localparam int SETTLE       = 4;
  localparam int IDLE_LIMIT   = 2000;

  // per-frame verdict prediction and result checking
  class verdict_tracker;
    logic [47:0] local_mac;
    logic [31:0] local_ip;
    logic [11:0] vlan_id;
    logic [31:0] peer_ip;
    logic [5:0]  pos;
    bit          fields_ok;
    logic [47:0] snd_mac;
    out_item_t   expected_verdicts[$];
    int          errors;

    function new();
      local_mac = '0;
      local_ip  = '0;
      vlan_id   = '0;
      peer_ip   = '0;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos       = '0;
      fields_ok = 1'b1;
      snd_mac   = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [47:0] v);
      case (idx)
        CFG_LOCAL_MAC: local_mac = v;
        CFG_LOCAL_IP:  local_ip  = v[31:0];
        CFG_VLAN_ID:   vlan_id   = v[11:0];
        CFG_PEER_IP:   peer_ip   = v[31:0];
        default: ;
      endcase
    endfunction

    // does byte b carry the value required at offset p
    function bit byte_fits(int p, logic [7:0] b);
      if (p < 6)
        return b == local_mac[47 - 8*p -: 8];
      case (p)
        POS_TYPE:       return b == TYPE_VLAN[15:8];
        POS_TYPE + 1:   return b == TYPE_VLAN[7:0];
        POS_TAG:        return b[3:0] == vlan_id[11:8];
        POS_TAG + 1:    return b == vlan_id[7:0];
        POS_INNER:      return b == TYPE_ARP[15:8];
        POS_INNER + 1:  return b == TYPE_ARP[7:0];
        POS_OPCODE:     return b == OP_REPLY[15:8];
        POS_OPCODE + 1: return b == OP_REPLY[7:0];
        default: ;
      endcase
      if (p >= POS_SPA && p < POS_SPA + 4)
        return b == peer_ip[31 - 8*(p - int'(POS_SPA)) -: 8];
      if (p >= POS_TPA && p < POS_TPA + 4)
        return b == local_ip[31 - 8*(p - int'(POS_TPA)) -: 8];
      return 1'b1;
    endfunction

    function void note_byte(in_item_t it);
      out_item_t v;
      if (pos < FRAME_LEN) begin
        if (!byte_fits(int'(pos), it.rx_byte))
          fields_ok = 1'b0;
        if (pos >= POS_SMAC && pos < POS_SPA)
          snd_mac[47 - 8*(int'(pos) - int'(POS_SMAC)) -: 8] = it.rx_byte;
        pos = pos + 6'd1;
      end
      // a verdict only on the last byte of a frame
      if (it.frame_end) begin
        v.frame_short   = pos < FRAME_LEN;
        v.frame_matched = fields_ok && !v.frame_short;
        v.peer_mac      = snd_mac;
        expected_verdicts.push_back(v);
        clear_frame();
      end
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, got);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.frame_matched !== want.frame_matched) begin
        $display("%0t: frame_matched expected %0b actual %0b", $time,
                 want.frame_matched, got.frame_matched);
        errors++;
      end
      if (got.frame_short !== want.frame_short) begin
        $display("%0t: frame_short expected %0b actual %0b", $time,
                 want.frame_short, got.frame_short);
        errors++;
      end
      if (got.peer_mac !== want.peer_mac) begin
        $display("%0t: peer_mac expected %h actual %h", $time,
                 want.peer_mac, got.peer_mac);
        errors++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_LOCAL_MAC;
  logic [47:0] cfg_data = '0;

  verdict_tracker sb;
  logic [7:0]     frame_bytes[$];
  int             idle_cycles = 0;

  vlan_arp_reply_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // write one register; valid stays up when more writes follow
  task automatic write_reg(cfg_idx_t idx, logic [47:0] v, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    if (last)
      cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(logic [47:0] mac, logic [47:0] ip,
                              logic [47:0] vid, logic [47:0] peer);
    write_reg(CFG_LOCAL_MAC, mac, 1'b0);
    write_reg(CFG_LOCAL_IP, ip, 1'b0);
    write_reg(CFG_VLAN_ID, vid, 1'b0);
    write_reg(CFG_PEER_IP, peer, 1'b1);
  endtask

  // one frame byte; valid is dropped only when a gap follows
  task automatic push_byte(in_item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(it);
  endtask

  task automatic send_frame();
    in_item_t it;
    bit       steady;
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      it.rx_byte   = frame_bytes[i];
      it.frame_end = (i == frame_bytes.size() - 1);
      push_byte(it, steady ? 0 : $urandom_range(0, 10));
    end
  endtask

  function automatic void put(int i, logic [7:0] b);
    if (i < frame_bytes.size())
      frame_bytes[i] = b;
  endfunction

  function automatic bit checked_pos(int p);
    return p < 6 || (p >= POS_TYPE && p < POS_TYPE + 6) || p == POS_OPCODE ||
           p == POS_OPCODE + 1 || (p >= POS_SPA && p < POS_SPA + 4) ||
           (p >= POS_TPA && p < POS_TPA + 4);
  endfunction

  // well-formed reply for the current settings, cut or padded to len
  task automatic build_reply(int len);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < 6; k++)
      put(int'(POS_DMAC) + k, sb.local_mac[47 - 8*k -: 8]);
    put(int'(POS_TYPE), TYPE_VLAN[15:8]);
    put(POS_TYPE + 1, TYPE_VLAN[7:0]);
    // priority bits stay random
    put(int'(POS_TAG), {4'($urandom_range(0, 15)), sb.vlan_id[11:8]});
    put(POS_TAG + 1, sb.vlan_id[7:0]);
    put(int'(POS_INNER), TYPE_ARP[15:8]);
    put(POS_INNER + 1, TYPE_ARP[7:0]);
    put(int'(POS_OPCODE), OP_REPLY[15:8]);
    put(POS_OPCODE + 1, OP_REPLY[7:0]);
    for (int k = 0; k < 4; k++) begin
      put(int'(POS_SPA) + k, sb.peer_ip[31 - 8*k -: 8]);
      put(int'(POS_TPA) + k, sb.local_ip[31 - 8*k -: 8]);
    end
  endtask

  // mostly replies, some broken, short or random frames
  task automatic build_frame();
    int pick;
    int p;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      build_reply($urandom_range(46, 48));
    else if (pick < 58)
      build_reply($urandom_range(47, 80));
    else if (pick < 78) begin
      build_reply($urandom_range(46, 60));
      repeat ($urandom_range(1, 2)) begin
        do p = $urandom_range(0, 45); while (!checked_pos(p));
        frame_bytes[p] ^= (p == POS_TAG) ? 8'($urandom_range(1, 15))
                                         : 8'($urandom_range(1, 255));
      end
    end else if (pick < 90)
      build_reply($urandom_range(1, 45));
    else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 70)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(int min_bytes, int min_frames);
    int nbytes;
    int nframes;
    nbytes  = 0;
    nframes = 0;
    while (nbytes < min_bytes || nframes < min_frames) begin
      build_frame();
      nbytes += frame_bytes.size();
      nframes++;
      send_frame();
    end
    in_valid <= 1'b0;
  endtask

  // wait for every verdict, then let the pipeline empty
  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result side with random stalls and stall-free stretches
  initial begin
    bit steady;
    int stall;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 5) == 0)
        steady = ~steady;
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_verdict(out_data);
    end
  end

  // main sequence
  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // short directed frames on reset settings: lone byte, then a frame
    // cut inside the sender MAC with alternating extreme bytes
    frame_bytes = '{8'hA5};
    send_frame();
    frame_bytes.delete();
    for (int i = 0; i < 28; i++)
      frame_bytes.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
    send_frame();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph == 1)
        program_regs({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
      else if (ph == 3)
        program_regs('0, '0, '0, '0);
      else if (ph > 0)
        program_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      run_random(PHASE_BYTES, PHASE_FRAMES);
      drain_results();
    end

    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
